@@ rtl/xrs_pkg.sv @@
// ----------------------------------------------------------------------------
// xrs_pkg
// shared types and constants of the xorshift128 random source
// ----------------------------------------------------------------------------
package xrs_pkg;

  localparam logic [31:0] SeedA    = 32'd123456789;
  localparam logic [31:0] SeedB    = 32'd362436069;
  localparam logic [31:0] SeedC    = 32'd521288629;
  localparam logic [31:0] SeedD    = 32'd88675123;
  localparam logic [31:0] RawMask  = 32'h7fffffff;
  localparam logic [31:0] MantMask = 32'h007fffff;
  localparam logic [31:0] OneBits  = 32'h3f800000;

  localparam logic [2:0] CmdRaw    = 3'd0;
  localparam logic [2:0] CmdBound  = 3'd1;
  localparam logic [2:0] CmdRange  = 3'd2;
  localparam logic [2:0] CmdMedian = 3'd3;
  localparam logic [2:0] CmdUnit   = 3'd4;

  // biased exponent of 2^(p-23) is ExpBase + p
  localparam logic [7:0] ExpBase = OneBits[30:23] - 8'd23;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] int_value;
    logic        [31:0] float_bits;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_DIVIDE,
    ST_NORM,
    ST_DONE
  } state_e;

endpackage

@@ rtl/xorshift128_random_source_unit.sv @@
// ----------------------------------------------------------------------------
// xorshift128_random_source_unit
// xorshift128 generator answering raw, bounded, ranged, median and unit float words
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   in       input      valid / stall      in_word_i  (cmd, operand_a, operand_b)
//   out      output     valid / stall      out_word_o (int_value, float_bits)
//   cfg      input      valid / ready      cfg_data_i (seed)
//
// one word at a time: raw and skipped commands pass from accept through the
// advance state to the done state, unit float takes one bit of normalising shift
// per cycle, modulo commands run 32 steps of the shared radix-2 divider
// reset loads the default state words; no clearing pass
// a stalled result sits in the output register while the next word is taken
module xorshift128_random_source_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  xrs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xrs_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import xrs_pkg::*;

  state_e      state_q, state_d;
  logic [2:0]  cmd_q;
  logic [31:0] lo_q, span_q;
  logic [22:0] mant_q;
  logic [4:0]  pos_q;
  out_word_t   res_q, out_word_q;
  logic        out_valid_q;

  logic        in_accept, out_free, skip, advance, load_out;
  logic [30:0] raw_next;
  div_ctrl_t   div_ctrl;
  div_stat_t   div_stat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_q) inside
      CmdRaw, CmdUnit:              skip = 1'b0;
      CmdBound, CmdRange, CmdMedian: skip = (span_q == 32'd0);
      default:                      skip = 1'b1;
    endcase
  end

  xrs_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cfg_valid_i && cfg_ready_o),
    .seed_i     (cfg_data_i),
    .advance_i  (advance),
    .raw_next_o (raw_next)
  );

  xrs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (skip || cmd_q == CmdRaw) begin
          state_d = ST_DONE;
        end else if (cmd_q == CmdUnit) begin
          state_d = (raw_next[22:0] == 23'd0) ? ST_DONE : ST_NORM;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) state_d = ST_DONE;
      end
      ST_NORM: begin
        if (mant_q[22]) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o        = 1'b1;
    cfg_ready_o       = 1'b0;
    advance           = 1'b0;
    load_out          = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = {1'b0, raw_next};
    div_ctrl.divisor  = span_q[31] ? 32'(32'd0 - span_q) : span_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
      end
      ST_ADVANCE: begin
        advance        = !skip;
        div_ctrl.start = !skip && cmd_q != CmdRaw && cmd_q != CmdUnit;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_word_q <= res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_q <= in_word_i.cmd;
          case (in_word_i.cmd)
            CmdRange: begin
              lo_q   <= in_word_i.operand_a;
              span_q <= 32'(in_word_i.operand_b - in_word_i.operand_a);
            end
            CmdMedian: begin
              lo_q   <= 32'(in_word_i.operand_a - in_word_i.operand_b);
              span_q <= {in_word_i.operand_b[30:0], 1'b0};
            end
            default: begin
              lo_q   <= '0;
              span_q <= in_word_i.operand_b;
            end
          endcase
        end
      end
      ST_ADVANCE: begin
        res_q  <= {((!skip && cmd_q == CmdRaw) ? {1'b0, raw_next} : 32'd0), 32'd0};
        mant_q <= raw_next[22:0] & MantMask[22:0];
        pos_q  <= 5'd22;
      end
      ST_DIVIDE: begin
        if (div_stat.done) res_q.int_value <= 32'(div_stat.remainder + lo_q);
      end
      ST_NORM: begin
        if (mant_q[22]) begin
          res_q.float_bits <= {1'b0, 8'(ExpBase + {3'b000, pos_q}), mant_q[21:0], 1'b0};
        end else begin
          mant_q <= {mant_q[21:0], 1'b0};
          pos_q  <= pos_q - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/xrs_state.sv @@
// ----------------------------------------------------------------------------
// xrs_state
// xorshift128 state words, seed reload and one-step advance
// ----------------------------------------------------------------------------
module xrs_state (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] seed_i,
  input  logic        advance_i,
  output logic [30:0] raw_next_o
);
  import xrs_pkg::*;

  logic [31:0] word_a_q, word_b_q, word_c_q, word_d_q;
  logic [31:0] word_d_d;
  logic [31:0] t;

  always_comb begin
    t        = word_a_q ^ (word_a_q << 11);
    word_d_d = (word_d_q ^ (word_d_q >> 19)) ^ (t ^ (t >> 8));
  end

  assign raw_next_o = word_d_d[30:0] & RawMask[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= SeedA;
      word_b_q <= SeedB;
      word_c_q <= SeedC;
      word_d_q <= SeedD;
    end else if (load_i) begin
      word_a_q <= SeedA;
      word_b_q <= SeedB;
      word_c_q <= SeedC;
      // zero or negative seed falls back to the default
      word_d_q <= (seed_i == 32'd0 || seed_i[31]) ? SeedD : seed_i;
    end else if (advance_i) begin
      word_a_q <= word_b_q;
      word_b_q <= word_c_q;
      word_c_q <= word_d_q;
      word_d_q <= word_d_d;
    end
  end

endmodule

@@ rtl/xrs_divider.sv @@
// ----------------------------------------------------------------------------
// xrs_divider
// radix-2 restoring divider, one quotient bit per cycle, remainder only
// ----------------------------------------------------------------------------
module xrs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrs_pkg::div_ctrl_t ctrl_i,
  output xrs_pkg::div_stat_t stat_o
);
  import xrs_pkg::*;

  logic [5:0]  count_q;
  logic        busy_q, done_q;
  logic [31:0] rem_q, num_q, div_q;
  logic [32:0] shifted;
  logic        fits;

  always_comb begin
    shifted = {rem_q, num_q[31]};
    fits    = shifted >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        count_q <= 6'd32;
      end else if (busy_q) begin
        count_q <= count_q - 6'd1;
        if (count_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      num_q <= ctrl_i.dividend;
      div_q <= ctrl_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      rem_q <= fits ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
    end
  end

  assign stat_o.done      = done_q;
  assign stat_o.remainder = rem_q;

endmodule

@@ rtl/xrs_checker.sv @@
// ----------------------------------------------------------------------------
// xrs_checker
// port level checks of the xorshift128 random source
// ----------------------------------------------------------------------------
module xrs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input xrs_pkg::out_word_t out_word_o,
  input logic               cfg_ready_o
);
  import xrs_pkg::*;

  // one word in flight: busy straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in flight");

  // seed writes only while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !in_stall_o)
    else $error("seed port open while busy");

  // integer and float results never both set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.float_bits == 32'd0 || out_word_o.int_value == 32'sd0))
    else $error("both result fields set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result changed under stall");

endmodule

bind xorshift128_random_source_unit xrs_checker u_xrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_ready_o (cfg_ready_o)
);

@@ tb/xorshift128_random_source_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xorshift128_random_source_unit_test
// self-checking bench: a cycle-free model of the generator predicts each
// answer word from the accepted request and the current seed; requests cover
// every command with edge operands, seed writes at the extremes, a long
// output hold-off and three idling mixes on the two channels
// ----------------------------------------------------------------------------
module xorshift128_random_source_unit_test;
  import xrs_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [31:0] gen_a, gen_b, gen_c, gen_d;
  out_word_t   answers_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int fail_count    = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int seeds_written = 0;
  int cmd_seen[8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xorshift128_random_source_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // generator model

  function automatic void load_generator(logic [31:0] seed);
    gen_a = SeedA;
    gen_b = SeedB;
    gen_c = SeedC;
    gen_d = (seed == '0 || seed[31]) ? SeedD : seed;
  endfunction

  function automatic logic [31:0] next_raw();
    logic [31:0] t;
    t = gen_a ^ (gen_a << 11);
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = gen_d;
    gen_d = gen_d ^ (gen_d >> 19) ^ t ^ (t >> 8);
    return gen_d & RawMask;
  endfunction

  function automatic logic [31:0] abs_word(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] ranged_pick(logic [31:0] lo, logic [31:0] span);
    return (next_raw() % abs_word(span)) + lo;
  endfunction

  function automatic logic [31:0] unit_float(logic [31:0] raw);
    logic [31:0] m;
    int p;
    m = raw & MantMask;
    if (m == '0) return '0;
    p = 22;
    while (!m[p]) p--;
    return (({24'd0, ExpBase} + p) << 23) | ((m << (23 - p)) & MantMask);
  endfunction

  function automatic out_word_t predict_answer(in_word_t w);
    out_word_t r;
    logic [31:0] a, b, lo, span;
    r = '0;
    a = w.operand_a;
    b = w.operand_b;
    case (w.cmd)
      CmdRaw: r.int_value = next_raw();
      CmdBound: begin
        if (b != '0) r.int_value = next_raw() % abs_word(b);
      end
      CmdRange: begin
        span = b - a;
        if (span != '0) r.int_value = ranged_pick(a, span);
      end
      CmdMedian: begin
        lo = a - b;
        span = (a + b) - lo;
        if (span != '0) r.int_value = ranged_pick(lo, span);
      end
      CmdUnit: r.float_bits = unit_float(next_raw());
      default: ;
    endcase
    return r;
  endfunction

  // checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected word", out_word.int_value, '0);
      end else begin
        want = answers_due.pop_front();
        words_checked++;
        if (out_word.int_value !== want.int_value)
          report_mismatch("int_value", out_word.int_value, want.int_value);
        if (out_word.float_bits !== want.float_bits)
          report_mismatch("float_bits", out_word.float_bits, want.float_bits);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // stimulus

  function automatic in_word_t make_word(logic [2:0] cmd, logic [31:0] a, logic [31:0] b);
    in_word_t w;
    w.cmd = cmd;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return '0;
      3: return 32'hffffffff;
      4, 5: return 32'($urandom_range(32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    if ($urandom_range(99) < 90) w.cmd = 3'($urandom_range(4));
    else w.cmd = 3'($urandom_range(7, 5));
    w.operand_a = random_operand();
    w.operand_b = random_operand();
    if (w.cmd == CmdRange && $urandom_range(15) == 0) w.operand_b = w.operand_a;
    return w;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    answers_due.push_back(predict_answer(w));
    cmd_seen[w.cmd]++;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    do @(negedge clk); while (answers_due.size() != 0);
  endtask

  task automatic write_seed(logic [31:0] seed);
    finish_stream();
    cfg_valid <= 1'b1;
    cfg_data  <= seed;
    do @(posedge clk); while (!cfg_ready);
    load_generator(seed);
    seeds_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // test tasks

  task automatic check_default_seed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) send_word(make_word(CmdRaw, $urandom, $urandom));
    finish_stream();
  endtask

  task automatic check_commands_directed();
    in_word_t plan[$];
    plan.push_back(make_word(CmdRaw,    32'hffffffff, 32'h80000000));
    plan.push_back(make_word(CmdBound,  32'h12345678, 32'h00000000));
    plan.push_back(make_word(CmdBound,  32'h00000000, 32'h00000001));
    plan.push_back(make_word(CmdBound,  32'h00000000, 32'hffffffff));
    plan.push_back(make_word(CmdBound,  32'h7fffffff, 32'h80000000));
    plan.push_back(make_word(CmdBound,  32'h80000000, 32'h7fffffff));
    plan.push_back(make_word(CmdBound,  32'hffffffff, 32'hfffffff9));
    plan.push_back(make_word(CmdRange,  32'h00000005, 32'h00000005));
    plan.push_back(make_word(CmdRange,  32'h80000000, 32'h7fffffff));
    plan.push_back(make_word(CmdRange,  32'h7fffffff, 32'h80000000));
    plan.push_back(make_word(CmdRange,  32'hffffff9c, 32'h00000064));
    plan.push_back(make_word(CmdRange,  32'h00000064, 32'hffffff9c));
    plan.push_back(make_word(CmdMedian, 32'h00001000, 32'h00000000));
    plan.push_back(make_word(CmdMedian, 32'h00000000, 32'h80000000));
    plan.push_back(make_word(CmdMedian, 32'h7fffffff, 32'h00000001));
    plan.push_back(make_word(CmdMedian, 32'hffffffce, 32'hfffffff6));
    plan.push_back(make_word(CmdMedian, 32'h00000000, 32'h40000000));
    plan.push_back(make_word(CmdUnit,   32'hffffffff, 32'hffffffff));
    plan.push_back(make_word(CmdUnit,   32'h00000000, 32'h00000000));
    plan.push_back(make_word(CmdUnit,   32'h80000000, 32'h7fffffff));
    plan.push_back(make_word(3'd5,      32'hffffffff, 32'hffffffff));
    plan.push_back(make_word(3'd6,      32'h80000000, 32'h00000001));
    plan.push_back(make_word(3'd7,      32'h7fffffff, 32'h80000000));
    plan.push_back(make_word(CmdRaw,    32'h00000000, 32'h00000000));
    foreach (plan[i]) send_word(plan[i]);
    finish_stream();
  endtask

  task automatic check_seed_register();
    logic [31:0] seeds[$];
    seeds = '{32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001, 32'h7fffffff,
              $urandom | 32'h1};
    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_word(make_word(CmdRaw, '0, '0));
      send_word(make_word(CmdUnit, '0, '0));
      send_word(make_word(CmdBound, '0, 32'($urandom_range(1000, 1))));
    end
    finish_stream();
  endtask

  task automatic check_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = HoldCycles;
    @(negedge clk);
    repeat (8) send_word(random_word());
    finish_stream();
    send_word(make_word(CmdBound, '0, 32'h80000000));
    finish_stream();
  endtask

  task automatic run_random_phase(int count, int s_pct, int r_pct);
    logic [31:0] seed;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    case ($urandom_range(3))
      0: seed = 32'($urandom_range(1000, 1));
      1: seed = 32'h80000000 | $urandom;
      default: seed = $urandom;
    endcase
    write_seed(seed);
    repeat (count) send_word(random_word());
    finish_stream();
  endtask

  initial begin
    load_generator(SeedD);
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    check_default_seed();
    check_commands_directed();
    check_seed_register();
    check_backpressure();
    run_random_phase(285, 20, 63);
    run_random_phase(285, 63, 20);
    run_random_phase(285, 0, 0);

    finish_stream();
    repeat (DrainCycles) @(negedge clk);

    $display("%0d requests answered and checked under %0d seed writes: raw %0d, modulo %0d,",
             words_checked, seeds_written, cmd_seen[CmdRaw], cmd_seen[CmdBound]);
    $display("range %0d, median %0d, unit %0d, unused codes %0d; one %0d-cycle output hold-off",
             cmd_seen[CmdRange], cmd_seen[CmdMedian], cmd_seen[CmdUnit],
             words_sent - cmd_seen[CmdRaw] - cmd_seen[CmdBound] - cmd_seen[CmdRange]
             - cmd_seen[CmdMedian] - cmd_seen[CmdUnit], HoldCycles);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/xrs_pkg.sv
rtl/xrs_state.sv
rtl/xrs_divider.sv
rtl/xorshift128_random_source_unit.sv
rtl/xrs_checker.sv
tb/xorshift128_random_source_unit_test.sv
